>>> rtl/core/mm_pkg.sv
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int REG_IDX_W = 2;
  localparam int OUT_IDX_W = 3;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(2 * DEPTH + 1);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_WAIT
  } mm_state_e;

  // Control that travels with each read of the two stores.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Clamp a dimension register to 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

endpackage

>>> rtl/core/mm_ram.sv
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mm_mac.sv
module mm_mac import mm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  input  logic              consume_i,
  output logic              acc_valid_o,
  output logic [DATA_W-1:0] product_o,
  output logic              saturated_o
);

  mac_ctl_t                  ctl1_q, ctl2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted;
  logic                      acc_valid_q;
  logic                      fits;

  // ctl1 lines up with the store read data, ctl2 with the product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      acc_valid_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      if (ctl2_q.valid && ctl2_q.last) begin
        acc_valid_q <= 1'b1;
      end else if (consume_i) begin
        acc_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl1_q.valid) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
    if (ctl2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    if (ctl2_q.first) begin
      acc_d = prod_ext;
    end else begin
      acc_d = acc_q + prod_ext;
    end
  end

  // Drop the fraction bits, then clip to the 32-bit range.
  assign shifted = acc_q >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    if (fits) begin
      product_o   = shifted[DATA_W-1:0];
      saturated_o = 1'b0;
    end else begin
      product_o   = acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX;
      saturated_o = 1'b1;
    end
  end

  assign acc_valid_o = acc_valid_q;

endmodule

>>> rtl/core/matrix_multiply.sv
// Matrix multiplier for signed Q16.16 data. Stream in the rows_a x inner_dim
// elements of A row-major, then the inner_dim x cols_b elements of B row-major,
// one element per cycle while in_ready_o is high; after the last B beat the
// block drives C = A*B row-major, each beat tagged with its row, column, a
// saturation flag and a last mark on the final element. A and B sit in two
// 64-entry single-port-read RAMs; one multiply-accumulate unit reads one A and
// one B entry per cycle; each result goes through read, multiply, accumulate
// and a registered output. Loading resumes while the last result beat is still
// waiting at the output. Sums are kept exact in a wide accumulator, shifted
// right arithmetically by 16 and clipped to 32 bits. Dimension registers clamp
// 0 to 1 and values above 8 to 8; writing one while loading restarts loading.
module matrix_multiply import mm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DATA_W-1:0]    element_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    product_o,
  output logic [OUT_IDX_W-1:0] row_index_o,
  output logic [OUT_IDX_W-1:0] col_index_o,
  output logic                 saturated_o,
  output logic                 last_o
);

  logic [CFG_W-1:0]      rows_a_q, inner_dim_q, cols_b_q;
  logic [DIM_W-1:0]      r_eff, n_eff, c_eff;
  logic [2*DIM_W-1:0]    rn, nc;
  logic [CNT_W-1:0]      left_len, total, r_off;
  logic                  cfg_hit;

  mm_state_e             state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ADDR_W-1:0]     row_base_q, row_base_d, b_addr_q, b_addr_d;
  logic [ADDR_W-1:0]     a_addr;

  logic                  in_fire, out_free, emit;
  logic                  k_last, j_last, i_last;
  logic                  left_we, right_we;
  logic [DATA_W-1:0]     a_rdata, b_rdata;
  mac_ctl_t              mac_ctl;
  logic                  acc_valid;
  logic [DATA_W-1:0]     mac_product;
  logic                  mac_sat;

  logic                  out_valid_q;
  logic [DATA_W-1:0]     product_q;
  logic [OUT_IDX_W-1:0]  row_q, col_q;
  logic                  sat_q, last_q;

  // Configuration
  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_ROWS_A || cfg_index_i == REG_INNER_DIM
                                || cfg_index_i == REG_COLS_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ROWS_A) begin
        rows_a_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_INNER_DIM) begin
        inner_dim_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_COLS_B) begin
        cols_b_q <= cfg_data_i;
      end
    end
  end

  assign r_eff    = eff_dim(rows_a_q);
  assign n_eff    = eff_dim(inner_dim_q);
  assign c_eff    = eff_dim(cols_b_q);
  assign rn       = r_eff * n_eff;
  assign nc       = n_eff * c_eff;
  assign left_len = CNT_W'(rn);
  assign total    = CNT_W'(rn) + CNT_W'(nc);
  assign r_off    = cnt_q - left_len;

  // Handshakes
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (state_q == ST_WAIT) && acc_valid && out_free;

  assign k_last = (DIM_W'(k_q) == n_eff - DIM_W'(1));
  assign j_last = (DIM_W'(j_q) == c_eff - DIM_W'(1));
  assign i_last = (DIM_W'(i_q) == r_eff - DIM_W'(1));

  assign left_we  = in_fire && (cnt_q < left_len);
  assign right_we = in_fire && !(cnt_q < left_len);
  assign a_addr   = row_base_q + ADDR_W'(k_q);

  assign mac_ctl.valid = (state_q == ST_MAC);
  assign mac_ctl.first = (k_q == '0);
  assign mac_ctl.last  = k_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      row_base_q <= '0;
      b_addr_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      row_base_q <= row_base_d;
      b_addr_q   <= b_addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    row_base_d = row_base_q;
    b_addr_d   = b_addr_q;
    unique case (state_q)
      ST_LOAD: begin
        if (cfg_hit) begin
          cnt_d = '0;
        end else if (in_fire) begin
          if (cnt_q + CNT_W'(1) == total) begin
            // Last B beat: start the product at C(0,0).
            cnt_d      = '0;
            i_d        = '0;
            j_d        = '0;
            k_d        = '0;
            row_base_d = '0;
            b_addr_d   = '0;
            state_d    = ST_MAC;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_MAC: begin
        if (k_last) begin
          k_d     = '0;
          state_d = ST_WAIT;
        end else begin
          k_d      = k_q + IDX_W'(1);
          b_addr_d = b_addr_q + ADDR_W'(c_eff);
        end
      end
      ST_WAIT: begin
        if (emit) begin
          if (j_last) begin
            j_d        = '0;
            i_d        = i_q + IDX_W'(1);
            row_base_d = row_base_q + ADDR_W'(n_eff);
            b_addr_d   = '0;
          end else begin
            j_d      = j_q + IDX_W'(1);
            b_addr_d = ADDR_W'(j_q + IDX_W'(1));
          end
          state_d = (i_last && j_last) ? ST_LOAD : ST_MAC;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  mm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (element_i),
    .raddr_i (a_addr),
    .rdata_o (a_rdata)
  );

  mm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (r_off[ADDR_W-1:0]),
    .wdata_i (element_i),
    .raddr_i (b_addr_q),
    .rdata_o (b_rdata)
  );

  mm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mac_ctl),
    .a_i         (a_rdata),
    .b_i         (b_rdata),
    .consume_i   (emit),
    .acc_valid_o (acc_valid),
    .product_o   (mac_product),
    .saturated_o (mac_sat)
  );

  // Output register: hold the beat until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      product_q <= mac_product;
      row_q     <= OUT_IDX_W'(i_q);
      col_q     <= OUT_IDX_W'(j_q);
      sat_q     <= mac_sat;
      last_q    <= i_last && j_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;
  assign row_index_o = row_q;
  assign col_index_o = col_q;
  assign saturated_o = sat_q;
  assign last_o      = last_q;

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < total)
    else $error("load count reached the element total");

  a_acc_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_valid |-> state_q == ST_WAIT)
    else $error("finished sum outside the wait state");

  a_cnt_idle_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_LOAD |-> cnt_q == '0)
    else $error("load count moved while computing");

endmodule
